// File: design/sab_pkg.sv
// Shared types, constants and helpers for the RGB565 sprite alpha blitter.
// No dependencies; used by sab_front, sab_queue, sab_back and the top level.
`default_nettype none

package sab_pkg;

   localparam int unsigned BUF_DIM_W    = 10;
   localparam int unsigned POS_W        = 9;
   localparam int unsigned ADDR_W       = 18;
   localparam int unsigned COORD_W      = 11;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [BUF_DIM_W-1:0] MAX_BUFFER_DIM = 10'd512;
   localparam logic [15:0]          DEFAULT_COLOR  = 16'h4A28;
   localparam logic [7:0]           OPAQUE_ALPHA   = 8'd250;
   localparam logic [31:0]          RECIP_255      = 32'd32897;
   localparam logic [7:0]           ALPHA_MAX      = 8'd255;

   typedef enum logic [2:0] {
      REG_TILE_WIDTH      = 3'd0,
      REG_TILE_HEIGHT     = 3'd1,
      REG_SPOT_X          = 3'd2,
      REG_SPOT_Y          = 3'd3,
      REG_BUFFER_ORIGIN_X = 3'd4,
      REG_BUFFER_ORIGIN_Y = 3'd5,
      REG_BUFFER_WIDTH    = 3'd6,
      REG_BUFFER_HEIGHT   = 3'd7
   } sab_reg_type;

   typedef enum logic [1:0] {
      OPACITY_NONE    = 2'd0,
      OPACITY_HALF    = 2'd1,
      OPACITY_QUARTER = 2'd2,
      OPACITY_FULL    = 2'd3
   } sab_opacity_type;

   // one classified sprite pixel between front and back
   typedef struct packed {
      logic                 on_buffer;
      logic                 last;
      logic [POS_W-1:0]     px;
      logic [POS_W-1:0]     py;
      logic [BUF_DIM_W-1:0] bw;
      logic [7:0]           alpha;
      logic [15:0]          fg;
      logic [15:0]          bg;
   } sab_item_type;

   // exact floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [31:0] prod;
      prod = {16'd0, x} * RECIP_255;
      return prod[30:23];
   endfunction

endpackage

`default_nettype wire

// File: design/sab_front.sv
// Front end: configuration registers, tile counters, clipping and alpha scaling.
// Depends on sab_pkg; feeds classified pixels into sab_queue.
`default_nettype none

module sab_front
   import sab_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [COORD_W-1:0] csr_wdata,
   input  wire logic               in_valid,
   input  wire logic [7:0]         in_alpha,
   input  wire logic [15:0]        in_color,
   input  wire logic               in_has_color,
   input  wire logic [1:0]         in_opacity,
   input  wire logic [15:0]        in_background,
   input  wire logic               in_ready,
   output sab_item_type            item
);

   logic [7:0]           tile_w_ff, tile_h_ff;
   logic [COORD_W-1:0]   spot_x_ff, spot_y_ff, org_x_ff, org_y_ff;
   logic [BUF_DIM_W-1:0] buf_w_ff, buf_h_ff;
   logic [7:0]           col_ff, col_in, row_ff, row_in;

   logic [7:0]           tw, th;
   logic [BUF_DIM_W-1:0] bw, bh;
   logic [12:0]          px, py;
   logic                 row_end, col_end, accept;
   logic [15:0]          alpha_num;
   logic [7:0]           alpha_scaled;

   assign accept = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_w_ff <= 8'd64;
         tile_h_ff <= 8'd64;
         spot_x_ff <= '0;
         spot_y_ff <= '0;
         org_x_ff  <= '0;
         org_y_ff  <= '0;
         buf_w_ff  <= 10'd466;
         buf_h_ff  <= 10'd466;
      end else if (csr_we) begin
         unique case (sab_reg_type'(csr_index))
            REG_TILE_WIDTH:      tile_w_ff <= csr_wdata[7:0];
            REG_TILE_HEIGHT:     tile_h_ff <= csr_wdata[7:0];
            REG_SPOT_X:          spot_x_ff <= csr_wdata;
            REG_SPOT_Y:          spot_y_ff <= csr_wdata;
            REG_BUFFER_ORIGIN_X: org_x_ff  <= csr_wdata;
            REG_BUFFER_ORIGIN_Y: org_y_ff  <= csr_wdata;
            REG_BUFFER_WIDTH:    buf_w_ff  <= csr_wdata[BUF_DIM_W-1:0];
            REG_BUFFER_HEIGHT:   buf_h_ff  <= csr_wdata[BUF_DIM_W-1:0];
            default:             tile_w_ff <= tile_w_ff;
         endcase
      end
   end

   always_comb begin
      tw = (tile_w_ff == 8'd0) ? 8'd1 : tile_w_ff;
      th = (tile_h_ff == 8'd0) ? 8'd1 : tile_h_ff;
      bw = (buf_w_ff > MAX_BUFFER_DIM) ? MAX_BUFFER_DIM : buf_w_ff;
      bh = (buf_h_ff > MAX_BUFFER_DIM) ? MAX_BUFFER_DIM : buf_h_ff;

      px = {{2{spot_x_ff[COORD_W-1]}}, spot_x_ff} - {6'd0, tw[7:1]} + {5'd0, col_ff}
         - {{2{org_x_ff[COORD_W-1]}}, org_x_ff};
      py = {{2{spot_y_ff[COORD_W-1]}}, spot_y_ff} - {6'd0, th[7:1]} + {5'd0, row_ff}
         - {{2{org_y_ff[COORD_W-1]}}, org_y_ff};

      row_end = ({1'b0, col_ff} + 9'd1) >= {1'b0, tw};
      col_end = ({1'b0, row_ff} + 9'd1) >= {1'b0, th};

      unique case (sab_opacity_type'(in_opacity))
         OPACITY_NONE:    alpha_num = 16'd0;
         OPACITY_HALF:    alpha_num = {1'b0, in_alpha, 7'd0};
         OPACITY_QUARTER: alpha_num = {1'b0, in_alpha, 7'd0} + {2'b0, in_alpha, 6'd0};
         OPACITY_FULL:    alpha_num = {in_alpha, 8'd0} - {8'd0, in_alpha};
         default:         alpha_num = 16'd0;
      endcase
      alpha_scaled = div255(alpha_num);

      item.on_buffer = !px[12] && (px[11:0] < {2'b0, bw})
                    && !py[12] && (py[11:0] < {2'b0, bh});
      item.last   = row_end && col_end;
      item.px     = px[POS_W-1:0];
      item.py     = py[POS_W-1:0];
      item.bw     = bw;
      item.alpha  = alpha_scaled;
      item.fg     = in_has_color ? in_color : DEFAULT_COLOR;
      item.bg     = in_background;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = 8'd0;
            row_in = col_end ? 8'd0 : row_ff + 8'd1;
         end else begin
            col_in = col_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

// File: design/sab_queue.sv
// Short register queue that decouples the front end from the blend back end.
// Depends on sab_pkg for the item type and queue depth.
`default_nettype none

module sab_queue
   import sab_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire sab_item_type push_item,
   output logic              not_full,
   input  wire logic         pop,
   output logic              not_empty,
   output sab_item_type      pop_item
);

   sab_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign not_full  = (count_ff != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/sab_back.sv
// Back end: address multiply, per-channel blend products, divide by 255, output register.
// Depends on sab_pkg; pops items from sab_queue and drives the result channel.
`default_nettype none

module sab_back
   import sab_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire sab_item_type      q_item,
   output logic                   q_pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic                   out_we,
   output logic [ADDR_W-1:0]      out_addr,
   output logic [15:0]            out_pixel,
   output logic                   out_last
);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_we_ff, s1_opaque_ff, s1_last_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [15:0]       s1_fg_ff, s1_bg_ff;
   logic [12:0]       s1_r_ff, s1_b_ff;
   logic [13:0]       s1_g_ff;

   logic              o_valid_ff, o_valid_in;
   logic              o_we_ff, o_last_ff;
   logic [ADDR_W-1:0] o_addr_ff;
   logic [15:0]       o_pixel_ff;

   logic              o_adv, s1_adv;
   logic [18:0]       addr_full;
   logic [7:0]        inv_a;
   logic [15:0]       blend_pix;
   logic [7:0]        r_q, g_q, b_q;

   assign o_adv  = !o_valid_ff || out_ready;
   assign s1_adv = !s1_valid_ff || o_adv;
   assign q_pop  = q_valid && s1_adv;

   assign out_valid = o_valid_ff;
   assign out_we    = o_we_ff;
   assign out_addr  = o_addr_ff;
   assign out_pixel = o_pixel_ff;
   assign out_last  = o_last_ff;

   always_comb begin
      addr_full = ({10'd0, q_item.py} * {9'd0, q_item.bw}) + {10'd0, q_item.px};
      inv_a     = ALPHA_MAX - q_item.alpha;
      s1_valid_in = s1_adv ? q_valid : s1_valid_ff;
      o_valid_in  = o_adv ? s1_valid_ff : o_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_we_ff     <= q_item.on_buffer && (q_item.alpha != 8'd0);
         s1_opaque_ff <= q_item.alpha >= OPAQUE_ALPHA;
         s1_last_ff   <= q_item.last;
         s1_addr_ff   <= q_item.on_buffer ? addr_full[ADDR_W-1:0] : '0;
         s1_fg_ff     <= q_item.fg;
         s1_bg_ff     <= q_item.bg;
         s1_r_ff <= ({8'd0, q_item.fg[15:11]} * {5'd0, q_item.alpha})
                  + ({8'd0, q_item.bg[15:11]} * {5'd0, inv_a});
         s1_g_ff <= ({8'd0, q_item.fg[10:5]} * {6'd0, q_item.alpha})
                  + ({8'd0, q_item.bg[10:5]} * {6'd0, inv_a});
         s1_b_ff <= ({8'd0, q_item.fg[4:0]} * {5'd0, q_item.alpha})
                  + ({8'd0, q_item.bg[4:0]} * {5'd0, inv_a});
      end
   end

   always_comb begin
      r_q = div255({3'd0, s1_r_ff});
      g_q = div255({2'd0, s1_g_ff});
      b_q = div255({3'd0, s1_b_ff});
      blend_pix = {r_q[4:0], g_q[5:0], b_q[4:0]};
   end

   always_ff @(posedge clock) begin
      if (o_adv) begin
         o_we_ff   <= s1_we_ff;
         o_last_ff <= s1_last_ff;
         o_addr_ff <= s1_addr_ff;
         if (!s1_we_ff) begin
            o_pixel_ff <= s1_bg_ff;
         end else if (s1_opaque_ff) begin
            o_pixel_ff <= s1_fg_ff;
         end else begin
            o_pixel_ff <= blend_pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/sprite_alpha_blit_rgb565_top.sv
// RGB565 alpha-blended sprite blitter, top level. Depends on sab_pkg, sab_front,
// sab_queue and sab_back.
// Path: an accepted pixel goes into the queue, then the back-end stage-1 registers,
// then the output register. Throughput: one pixel per cycle while rsp_tready is high,
// set by the two-stage back end; the four-entry queue absorbs output stalls.
// Reset: synchronous; clears the tile counters, queue and pipeline, restores registers.
`default_nettype none

module sprite_alpha_blit_rgb565_top
   import sab_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [COORD_W-1:0] csr_wdata,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // [7:0] sprite_alpha, [23:8] sprite_color, [25:24] opacity_level,
   // [41:26] background, [47:42] zero
   input  wire logic [47:0]        req_tdata,
   // [0] has_color
   input  wire logic               req_tuser,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // [17:0] buffer_address, [33:18] pixel, [39:34] zero
   output logic [39:0]             rsp_tdata,
   // [0] write_enable
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   sab_item_type      front_item, queue_item;
   logic              q_not_full, q_not_empty, q_pop;
   logic [ADDR_W-1:0] out_addr;
   logic [15:0]       out_pixel;

   assign req_tready = q_not_full;

   sab_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_valid      (req_tvalid),
      .in_alpha      (req_tdata[7:0]),
      .in_color      (req_tdata[23:8]),
      .in_has_color  (req_tuser),
      .in_opacity    (req_tdata[25:24]),
      .in_background (req_tdata[41:26]),
      .in_ready      (q_not_full),
      .item          (front_item)
   );

   sab_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && q_not_full),
      .push_item (front_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (queue_item)
   );

   sab_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_item    (queue_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_we    (rsp_tuser),
      .out_addr  (out_addr),
      .out_pixel (out_pixel),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_pixel, out_addr};

endmodule

`default_nettype wire
